/* sv/mtg_pkg.sv */
// Shared types, constants and the tempering function for the MT19937 generator.
// Used by mtg_ctrl, mtg_datapath and mt19937_generator_top; no dependencies.
package mtg_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	// index width also holds STATE_WORDS itself (pool exhausted marker)
	localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0]      word_t;

	localparam idx_t  LAST_IDX   = idx_t'(STATE_WORDS - 1);
	localparam idx_t  POOL_EMPTY = idx_t'(STATE_WORDS);

	localparam word_t MATRIX_A   = 32'h9908_b0df;
	localparam word_t UPPER_MASK = 32'h8000_0000;
	localparam word_t LOWER_MASK = 32'h7fff_ffff;
	localparam word_t SEED_MULT  = 32'h6c07_8965;
	localparam word_t TEMPER_B   = 32'h9d2c_5680;
	localparam word_t TEMPER_C   = 32'hefc6_0000;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_SEED_FIRST,
		DP_SEED_MUL,
		DP_SEED_ADD,
		DP_TW_PRE,
		DP_TW_NXT,
		DP_TW_FAR,
		DP_TW_WR,
		DP_DRAW_RD,
		DP_DRAW_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic exhausted;
		logic last;
	} dp_status_t;

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* sv/mtg_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module mtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/mtg_datapath.sv */
// Datapath: state memory, seed recurrence, twist update, read position and tempering.
// Depends on mtg_pkg and mtg_ram; driven by commands from mtg_ctrl.
module mtg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mtg_pkg::dp_cmd_t    cmd,
	input  mtg_pkg::word_t      seed_value,
	output mtg_pkg::dp_status_t status,
	output mtg_pkg::word_t      random_word
);
	import mtg_pkg::*;

	localparam int unsigned ADDR_W = $clog2(STATE_WORDS);

	idx_t  k_q;
	idx_t  pos_q;
	word_t p_q;
	word_t prod_q;
	word_t cur_q;
	word_t nxt_q;
	word_t random_word_q;

	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	word_t             wr_data;
	word_t             rd_data;

	logic [IDX_W:0] far_sum;
	idx_t           far_idx;
	idx_t           nxt_idx;
	word_t          twist_y;
	word_t          twist_word;
	word_t          seed_word;

	assign status.exhausted = (pos_q >= POOL_EMPTY);
	assign status.last      = (k_q == LAST_IDX);
	assign random_word      = random_word_q;

	assign far_sum   = {1'b0, k_q} + (IDX_W+1)'(TWIST_OFFSET);
	assign far_idx   = (far_sum >= (IDX_W+1)'(STATE_WORDS))
		? idx_t'(far_sum - (IDX_W+1)'(STATE_WORDS)) : idx_t'(far_sum);
	assign nxt_idx   = status.last ? '0 : k_q + idx_t'(1);

	assign twist_y    = (cur_q & UPPER_MASK) | (nxt_q & LOWER_MASK);
	assign twist_word = rd_data ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);
	assign seed_word  = prod_q + word_t'(k_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = k_q[ADDR_W-1:0];
		wr_data = twist_word;
		case (cmd.op)
			DP_SEED_FIRST: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = seed_value;
			end
			DP_SEED_ADD: begin
				wr_en   = 1'b1;
				wr_data = seed_word;
			end
			DP_TW_PRE: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			DP_TW_NXT: begin
				rd_en   = 1'b1;
				rd_addr = nxt_idx[ADDR_W-1:0];
			end
			DP_TW_FAR: begin
				rd_en   = 1'b1;
				rd_addr = far_idx[ADDR_W-1:0];
			end
			DP_TW_WR: begin
				wr_en   = 1'b1;
			end
			DP_DRAW_RD: begin
				rd_en   = 1'b1;
				rd_addr = pos_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	mtg_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// word counter and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			pos_q <= POOL_EMPTY;
		end else begin
			case (cmd.op)
				DP_SEED_FIRST: begin
					k_q <= idx_t'(1);
				end
				DP_SEED_ADD: begin
					k_q <= k_q + idx_t'(1);
					if (status.last) begin
						pos_q <= POOL_EMPTY;
					end
				end
				DP_TW_PRE: begin
					k_q <= '0;
				end
				DP_TW_WR: begin
					k_q <= k_q + idx_t'(1);
					if (status.last) begin
						pos_q <= '0;
					end
				end
				DP_DRAW_OUT: begin
					pos_q <= pos_q + idx_t'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_SEED_FIRST: begin
				p_q <= seed_value;
			end
			DP_SEED_MUL: begin
				prod_q <= SEED_MULT * (p_q ^ (p_q >> 30));
			end
			DP_SEED_ADD: begin
				p_q <= seed_word;
			end
			DP_TW_NXT: begin
				// first word of the pass comes from the preload read
				if (k_q == '0) begin
					cur_q <= rd_data;
				end
			end
			DP_TW_FAR: begin
				nxt_q <= rd_data;
			end
			DP_TW_WR: begin
				cur_q <= nxt_q;
			end
			DP_DRAW_OUT: begin
				random_word_q <= temper(rd_data);
			end
			default: begin
			end
		endcase
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POOL_EMPTY)
		else $error("read position beyond pool size");

	a_draw_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_DRAW_RD |-> !status.exhausted)
		else $error("draw read issued on exhausted pool");

	a_twist_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_TW_WR) && status.last |=> (pos_q == '0) && !status.exhausted)
		else $error("twist pass did not restart read position");

endmodule

/* sv/mtg_ctrl.sv */
// Controller FSM: sequences seeding, twist passes and draws; owns the handshakes.
// Depends on mtg_pkg; commands mtg_datapath through dp_cmd_t.
module mtg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	output logic                out_valid,
	input  logic                out_ready,
	input  mtg_pkg::dp_status_t status,
	output mtg_pkg::dp_cmd_t    cmd
);
	import mtg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SD_MUL,
		ST_SD_ADD,
		ST_TW_NXT,
		ST_TW_FAR,
		ST_TW_WR,
		ST_DR_RD,
		ST_DR_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_DR_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd.op  = DP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_SEED) begin
						cmd.op  = DP_SEED_FIRST;
						state_d = ST_SD_MUL;
					end else if (status.exhausted) begin
						cmd.op  = DP_TW_PRE;
						state_d = ST_TW_NXT;
					end else begin
						cmd.op  = DP_DRAW_RD;
						state_d = ST_DR_OUT;
					end
				end
			end
			ST_SD_MUL: begin
				cmd.op  = DP_SEED_MUL;
				state_d = ST_SD_ADD;
			end
			ST_SD_ADD: begin
				cmd.op  = DP_SEED_ADD;
				state_d = status.last ? ST_IDLE : ST_SD_MUL;
			end
			ST_TW_NXT: begin
				cmd.op  = DP_TW_NXT;
				state_d = ST_TW_FAR;
			end
			ST_TW_FAR: begin
				cmd.op  = DP_TW_FAR;
				state_d = ST_TW_WR;
			end
			ST_TW_WR: begin
				cmd.op  = DP_TW_WR;
				state_d = status.last ? ST_DR_RD : ST_TW_NXT;
			end
			ST_DR_RD: begin
				cmd.op  = DP_DRAW_RD;
				state_d = ST_DR_OUT;
			end
			ST_DR_OUT: begin
				// hold the read word until the output register frees up
				if (out_load) begin
					cmd.op  = DP_DRAW_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_twist_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_WR) && status.last |=> state_q == ST_DR_RD)
		else $error("twist pass did not hand over to the draw read");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("output beat lost after load");

	a_seed_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SD_ADD) && status.last |=> state_q == ST_IDLE)
		else $error("seed fill did not finish after the last word");

endmodule

/* sv/mt19937_generator_top.sv */
// MT19937 generator top: controller plus datapath over a 624-word state RAM.
// Draw: RAM read on accept, then ST_DR_OUT tempers the word into the output register
// once that frees; the next beat is accepted back in ST_IDLE. On an exhausted pool a
// twist pass over all 624 words runs first (one RAM read port, two reads and one
// write per word). Seed: multiply, then add and write, per word; no result beat.
// Reset: async active low; pool marked exhausted, state RAM not cleared.
module mt19937_generator_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           operation,
	input  mtg_pkg::word_t seed_value,
	output logic           out_valid,
	input  logic           out_ready,
	output mtg_pkg::word_t random_word
);
	import mtg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mtg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_value (seed_value),
		.status     (status),
		.random_word(random_word)
	);

endmodule

/* dv/tb.sv */
// Self-checking testbench for mt19937_generator_top: seeds and draws over valid/ready.
// Expected words come from a scoreboard class that keeps its own copy of the twister state.
// Depends on mtg_pkg and mt19937_generator_top.
`timescale 1ns / 100ps

module tb;
	import mtg_pkg::*;

	class mt19937_scoreboard;
		word_t       pool[STATE_WORDS];
		int unsigned pos;
		word_t       pending_words[$];
		int          errors;

		function new();
			pos    = STATE_WORDS;
			errors = 0;
		endfunction

		function void reseed(word_t seed);
			word_t p;
			pool[0] = seed;
			for (int k = 1; k < STATE_WORDS; k++) begin
				p       = pool[k-1];
				pool[k] = SEED_MULT * (p ^ (p >> 30)) + word_t'(k);
			end
			pos = STATE_WORDS;
		endfunction

		function void twist_pool();
			word_t y;
			for (int k = 0; k < STATE_WORDS; k++) begin
				y = (pool[k] & UPPER_MASK) | (pool[(k + 1) % STATE_WORDS] & LOWER_MASK);
				pool[k] = pool[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
					^ (y[0] ? MATRIX_A : word_t'(0));
			end
			pos = 0;
		endfunction

		function word_t tempered(word_t w);
			word_t a, b, c;
			a = w ^ (w >> 11);
			b = a ^ ((a << 7) & TEMPER_B);
			c = b ^ ((b << 15) & TEMPER_C);
			return c ^ (c >> 18);
		endfunction

		// one accepted input beat
		function void note_beat(logic op, word_t seed);
			if (op == OP_SEED) begin
				reseed(seed);
			end else begin
				if (pos >= STATE_WORDS)
					twist_pool();
				pending_words.push_back(tempered(pool[pos]));
				pos++;
			end
		endfunction

		// one accepted result beat
		function void check_word(word_t got);
			word_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected random_word %08h, none expected", $time, got);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					$display("%0t: random_word expected %08h actual %08h", $time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	logic  operation;
	word_t seed_value;
	logic  out_valid;
	logic  out_ready;
	word_t random_word;

	mt19937_scoreboard sb = new();
	int beats_sent = 0;
	int words_seen = 0;
	int send_quiet = 0;
	int recv_quiet = 0;

	mt19937_generator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pick a random wait length, with occasional stretches of no waiting at all
	function automatic int pick_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet_left = $urandom_range(10, 40);
		return $urandom_range(0, 8);
	endfunction

	task automatic send_beat(logic op, word_t seed);
		int gap;
		gap = pick_wait(send_quiet);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid   <= 1'b1;
		operation  <= op;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(op, seed);
		beats_sent++;
	endtask

	task automatic seed_then_draw(word_t seed, int draws);
		send_beat(OP_SEED, seed);
		repeat (draws) send_beat(OP_DRAW, $urandom);
	endtask

	function automatic word_t pick_seed();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// result side; holds off for a long stretch once so the input backs up
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (words_seen == 40) begin
				repeat (300) @(negedge clk) out_ready <= 1'b0;
				words_seen++;
			end
			stall = pick_wait(recv_quiet);
			repeat (stall) @(negedge clk) out_ready <= 1'b0;
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_word(random_word);
			words_seen++;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = OP_SEED;
		seed_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: extreme seeds, back-to-back seeds, reseed mid-pool
		seed_then_draw(32'h0000_0000, 3);
		seed_then_draw(32'hffff_ffff, 3);
		seed_then_draw(32'd5489, 2);
		send_beat(OP_SEED, 32'h0000_0001);
		seed_then_draw(32'h8000_0000, 2);
		seed_then_draw(32'h7fff_ffff, 1);
		seed_then_draw(32'h5555_5555, 1);
		send_beat(OP_DRAW, 32'haaaa_aaaa);

		// one long run past the end of the pool forces a second twist
		seed_then_draw(pick_seed(), $urandom_range(630, 680));
		while (beats_sent < 750) begin
			if ($urandom_range(0, 9) == 0)
				send_beat(OP_SEED, pick_seed());
			else
				seed_then_draw(pick_seed(), $urandom_range(1, 40));
		end
		@(negedge clk) in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
